// File: rtl/sfif_pkg.sv
// Package for the smallest free ID finder: field widths, bitmap geometry,
// status codes and the default ID range.
// Depends on nothing; used by the core and its top-level parameter defaults.
`default_nettype none

package sfif_pkg;

  // Default number of IDs tracked in the used-ID bitmap.
  localparam int MAX_IDS_DEF = 256;

  // Bitmap bits held in one memory word.
  localparam int WORD_BITS = 16;

  // Payload field widths.
  localparam int ID_W      = 16;
  localparam int FREE_ID_W = 9;
  localparam int STATUS_W  = 2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: rtl/smallest_free_id_finder_core.sv
// Smallest free ID finder: marks used IDs in a word-wide bitmap RAM and
// scans it for the first gap on the last item of a list.
// Depends on sfif_pkg and sfif_ram.
//
//   Channel  | Handshake        | Payload
//   ---------+------------------+-------------------------------------------
//   input    | start / busy     | in_id_value, in_has_id, in_is_last
//   result   | out_valid strobe | out_free_id, out_status
//
// Items that are not last transfer one per cycle; a read-modify-write of the
// bitmap word runs behind them, with the last written word forwarded.
// After a last item, busy stays high through a drain state that finishes
// that item's write, then through a scan of the bitmap words (MAX_IDS/16
// rounded up, at most), one read per word; an invalid list skips the scan.
// Reset and each result clear the bitmap at once through per-word valid bits.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none

module smallest_free_id_finder_core #(
  parameter int MAX_IDS = sfif_pkg::MAX_IDS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [sfif_pkg::ID_W-1:0]      in_id_value,
  input  wire logic                                  in_has_id,
  input  wire logic                                  in_is_last,
  output logic                                       out_valid,
  output logic             [sfif_pkg::FREE_ID_W-1:0] out_free_id,
  output logic             [sfif_pkg::STATUS_W-1:0]  out_status
);

  localparam int WB        = sfif_pkg::WORD_BITS;
  localparam int WBL       = $clog2(WB);
  localparam int ROWS      = (MAX_IDS + WB - 1) / WB;
  localparam int AW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LAST_BITS = MAX_IDS - (ROWS - 1) * WB;
  localparam int IDW       = sfif_pkg::ID_W;

  typedef enum logic [1:0] {
    S_LOAD,
    S_DRAIN,
    S_SCAN
  } state_t;

  state_t state_r;

  // Write stage of the read-modify-write.
  logic          s1_vld_r;
  logic [AW-1:0] s1_row_r;
  logic [WB-1:0] s1_mask_r;

  // Last written word, forwarded to a following access of the same row.
  logic          fw_vld_r;
  logic [AW-1:0] fw_row_r;
  logic [WB-1:0] fw_data_r;

  logic [ROWS-1:0] row_vld_r;
  logic            invalid_r;

  // Scan read issue and check stages.
  logic          scan_run_r;
  logic [AW-1:0] scan_addr_r;
  logic          chk_vld_r;
  logic [AW-1:0] chk_row_r;

  logic                             out_valid_r;
  logic [sfif_pkg::FREE_ID_W-1:0]   out_free_id_r;
  sfif_pkg::status_t                out_status_r;

  logic                  accept;
  logic                  id_low;
  logic                  id_high;
  logic                  mark;
  logic signed [IDW-1:0] id_m1;
  logic [IDW-1:0]        row_sh;
  logic [AW-1:0]         in_row;
  logic [WBL-1:0]        in_bit;

  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WB-1:0] ram_rdata;
  logic          fwd_hit;
  logic [WB-1:0] base_word;
  logic [WB-1:0] merged;

  logic [WB-1:0]  chk_word;
  logic [WB-1:0]  pad_mask;
  logic           fz_found;
  logic [WBL-1:0] fz_pos;
  logic [AW+WBL:0] fid_full;

  // Input decode: range checks and bitmap position of the ID.
  assign accept  = start && !busy;
  assign id_low  = in_id_value < $signed(IDW'(1));
  assign id_high = in_id_value > $signed(IDW'(MAX_IDS));
  assign mark    = in_has_id && !id_low && !id_high;
  assign id_m1   = in_id_value - $signed(IDW'(1));
  assign row_sh  = IDW'(id_m1) >> WBL;
  assign in_row  = row_sh[AW-1:0];
  assign in_bit  = id_m1[WBL-1:0];

  // The read port serves the input side while loading and the scan otherwise.
  assign ram_re    = (accept && mark) || ((state_r == S_SCAN) && scan_run_r);
  assign ram_raddr = (state_r == S_SCAN) ? scan_addr_r : in_row;

  // Merge the new bit into the freshest copy of the word.
  assign fwd_hit   = fw_vld_r && (fw_row_r == s1_row_r);
  assign base_word = fwd_hit ? fw_data_r :
                     (row_vld_r[s1_row_r] ? ram_rdata : '0);
  assign merged    = base_word | s1_mask_r;

  sfif_ram #(
    .WIDTH (WB),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_row_r),
    .wdata (merged),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Word under check; bits past MAX_IDS in the last word count as used.
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      pad_mask[b] = (chk_row_r == AW'(ROWS - 1)) && (b >= LAST_BITS);
    end
    chk_word = (row_vld_r[chk_row_r] ? ram_rdata : '0) | pad_mask;
  end

  // Lowest clear bit of the checked word.
  always_comb begin
    fz_found = ~&chk_word;
    fz_pos   = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (!chk_word[b]) begin
        fz_pos = WBL'(b);
      end
    end
  end

  assign fid_full = {1'b0, chk_row_r, fz_pos} + (AW + WBL + 1)'(1);

  // Control, bitmap bookkeeping and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      s1_vld_r    <= 1'b0;
      fw_vld_r    <= 1'b0;
      row_vld_r   <= '0;
      invalid_r   <= 1'b0;
      scan_run_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      s1_vld_r    <= accept && mark;
      if (accept && mark) begin
        s1_row_r  <= in_row;
        s1_mask_r <= WB'(1) << in_bit;
      end
      if (s1_vld_r) begin
        fw_vld_r            <= 1'b1;
        fw_row_r            <= s1_row_r;
        fw_data_r           <= merged;
        row_vld_r[s1_row_r] <= 1'b1;
      end
      chk_vld_r <= (state_r == S_SCAN) && scan_run_r;
      chk_row_r <= scan_addr_r;

      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (in_has_id && id_low) begin
              invalid_r <= 1'b1;
            end
            if (in_is_last) begin
              state_r <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          // The last item's write completes in this cycle.
          scan_addr_r <= '0;
          if (invalid_r) begin
            out_valid_r   <= 1'b1;
            out_free_id_r <= '0;
            out_status_r  <= sfif_pkg::STATUS_INVALID;
            row_vld_r     <= '0;
            fw_vld_r      <= 1'b0;
            invalid_r     <= 1'b0;
            state_r       <= S_LOAD;
          end else begin
            scan_run_r <= 1'b1;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_run_r) begin
            scan_addr_r <= scan_addr_r + AW'(1);
            if (scan_addr_r == AW'(ROWS - 1)) begin
              scan_run_r <= 1'b0;
            end
          end
          if (chk_vld_r && (fz_found || (chk_row_r == AW'(ROWS - 1)))) begin
            out_valid_r   <= 1'b1;
            out_free_id_r <= fz_found ? sfif_pkg::FREE_ID_W'(fid_full) : '0;
            out_status_r  <= fz_found ? sfif_pkg::STATUS_OK : sfif_pkg::STATUS_FULL;
            row_vld_r     <= '0;
            fw_vld_r      <= 1'b0;
            invalid_r     <= 1'b0;
            scan_run_r    <= 1'b0;
            chk_vld_r     <= 1'b0;
            state_r       <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign busy        = (state_r != S_LOAD);
  assign out_valid   = out_valid_r;
  assign out_free_id = out_free_id_r;
  assign out_status  = out_status_r;

endmodule

`default_nettype wire

// File: rtl/sfif_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; instanced by the smallest free ID finder core.
`default_nettype none

module sfif_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read in the same cycle as a write to that entry returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
